// ===== rtl/str_pkg.sv =====
`timescale 1ns / 1ps
package str_pkg;

  localparam int unsigned DelayWidthDef = 16;
  localparam int unsigned PosWidthDef   = 32;

  // Shared restoring divider: operand width and iteration counter width.
  localparam int unsigned DivW = 48;
  localparam int unsigned CntW = $clog2(DivW + 1);

  localparam logic [31:0] RateConstRst   = 32'd3141593;
  localparam logic [19:0] SpeedScaleRst  = 20'd6283;
  localparam logic [15:0] SingleDelayRst = 16'd1000;
  localparam logic [13:0] SpeedSqScale   = 14'd10000;

  // Configuration register indexes.
  localparam logic [1:0] CfgRate   = 2'd0;
  localparam logic [1:0] CfgScale  = 2'd1;
  localparam logic [1:0] CfgSingle = 2'd2;

  typedef enum logic [1:0] {
    PH_STOP  = 2'd0,
    PH_ACCEL = 2'd1,
    PH_RUN   = 2'd2,
    PH_DECEL = 2'd3
  } phase_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_ONE,
    OP_MD_GO,
    OP_MD,
    OP_NUM,
    OP_DEN,
    OP_MSL_GO,
    OP_MSL,
    OP_AL_GO,
    OP_AL,
    OP_DV_AL,
    OP_DV_GO,
    OP_DV_Q,
    OP_START_FIN,
    OP_STOP_STEP,
    OP_RUN_STEP,
    OP_RAMP_PREP,
    OP_RAMP_GO,
    OP_RAMP_Q,
    OP_RAMP_UPD,
    OP_OUT
  } dp_op_e;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] steps;
    logic [15:0]        accel;
    logic [15:0]        decel;
    logic [15:0]        speed;
    logic [15:0]        first_delay;
  } in_t;

  typedef struct packed {
    logic               pulse_level;
    logic [15:0]        next_delay;
    logic signed [31:0] position;
    logic               moving;
    logic               move_done;
    logic [1:0]         phase;
    logic               direction;
  } out_t;

  typedef struct packed {
    logic [31:0] rate_constant;
    logic [19:0] speed_scale;
    logic [15:0] single_delay;
  } cfg_t;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic   div_done;
    logic   mode;
    logic   full;
    logic   mag_zero;
    logic   mag_one;
    logic   al_le_msl;
    logic   out_busy;
    phase_e phase;
  } status_t;

endpackage

// ===== rtl/str_div.sv =====
`timescale 1ns / 1ps
module str_div import str_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            go_i,
  input  logic [DivW-1:0] n_i,
  input  logic [DivW-1:0] d_i,
  output logic            done_o,
  output logic [DivW-1:0] q_o,
  output logic [DivW-1:0] r_o
);

  logic [DivW-1:0] q_q, r_q, d_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q, done_q;
  logic [DivW:0]   shifted, diff;

  // One quotient bit per cycle, most significant first.
  assign shifted = {r_q, q_q[DivW-1]};
  assign diff    = shifted - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (go_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      q_q <= n_i;
      r_q <= '0;
      d_q <= d_i;
    end else if (busy_q) begin
      q_q <= {q_q[DivW-2:0], ~diff[DivW]};
      r_q <= diff[DivW] ? shifted[DivW-1:0] : diff[DivW-1:0];
    end
  end

  assign done_o = done_q;
  assign q_o    = q_q;
  assign r_o    = r_q;

endmodule

// ===== rtl/str_dp.sv =====
`timescale 1ns / 1ps
module str_dp import str_pkg::*; #(
  parameter int unsigned DelayWidth = DelayWidthDef,
  parameter int unsigned PosWidth   = PosWidthDef
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  in_t     in_data_i,
  input  cmd_t    cmd_i,
  output status_t status_o,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output out_t    out_data_o
);

  localparam logic [DivW-1:0] DelayMax = DivW'((64'd1 << DelayWidth) - 64'd1);
  localparam logic signed [39:0] DelayMaxS = $signed(40'(DelayMax));
  localparam logic signed [39:0] S33Max = 40'sd4294967295;
  localparam logic signed [39:0] S33Min = -40'sd4294967296;
  localparam logic [DivW-1:0] U32Max = DivW'(32'hFFFF_FFFF);
  localparam logic [DivW-1:0] Two32  = DivW'(33'h1_0000_0000);

  // Architectural state.
  phase_e                phase_q;
  logic                  dir_q, half_q, moving_q, done_q, out_valid_q;
  logic [DelayWidth-1:0] cur_q, min_q, last_q;
  logic signed [32:0]    rc_q, dv_q, rem_q;
  logic [31:0]           dss_q, steps_done_q;
  logic [PosWidth-1:0]   pos_q;

  // Working registers of the current transaction.
  logic                  mode_q, nneg_q, qneg_q;
  logic [31:0]           mag_q, msl_q, al_q;
  logic [15:0]           accel_q, decel_q, speed_q, c0_q, shown_q;
  logic [DivW-1:0]       prod_q, num_q;
  logic [DelayWidth-1:0] nd_q;
  out_t                  out_q;

  logic                  div_go, div_done;
  logic [DivW-1:0]       div_n, div_d, div_q, div_r;
  logic [39:0]           cur_w, dvd_mag, dsr_mag;
  logic signed [39:0]    dvd_s, dsr_s, q_s, r_s, nd_s;
  logic signed [32:0]    dv_al;
  logic signed [33:0]    ds_s;
  logic [31:0]           step_next;
  logic [DelayWidth-1:0] c0_d;

  function automatic logic [31:0] sat32nz(input logic [DivW-1:0] v);
    if (v > U32Max) return 32'hFFFF_FFFF;
    else if (v == '0) return 32'd1;
    else return v[31:0];
  endfunction

  function automatic logic signed [32:0] clamp33(input logic signed [39:0] v);
    if (v > S33Max) return {1'b0, {32{1'b1}}};
    else if (v < S33Min) return {1'b1, 32'd0};
    else return v[32:0];
  endfunction

  // Signed operands of the delay recurrence, taken apart into sign and magnitude.
  assign cur_w   = 40'(cur_q);
  assign dvd_s   = $signed(cur_w << 1) + 40'(rem_q);
  assign dsr_s   = (40'(rc_q) <<< 2) + 40'sd1;
  assign dvd_mag = dvd_s[39] ? 40'(-dvd_s) : 40'(dvd_s);
  assign dsr_mag = dsr_s[39] ? 40'(-dsr_s) : 40'(dsr_s);

  assign q_s  = qneg_q ? -$signed(div_q[39:0]) : $signed(div_q[39:0]);
  assign r_s  = nneg_q ? -$signed(div_r[39:0]) : $signed(div_r[39:0]);
  assign nd_s = $signed(cur_w) - q_s;

  assign dv_al     = $signed({1'b0, al_q}) - $signed({1'b0, mag_q});
  assign ds_s      = $signed({2'b00, mag_q}) + 34'(dv_q);
  assign step_next = steps_done_q + 32'd1;
  assign c0_d      = DelayWidth'(c0_q);

  always_comb begin
    div_go = 1'b1;
    div_n  = '0;
    div_d  = '0;
    case (cmd_i.op)
      OP_MD_GO: begin
        div_n = DivW'(cfg_i.rate_constant);
        div_d = DivW'(speed_q);
      end
      OP_MSL_GO: begin
        div_n = num_q;
        div_d = prod_q;
      end
      OP_AL_GO: begin
        div_n = prod_q;
        div_d = DivW'(accel_q) + DivW'(decel_q);
      end
      OP_DV_GO: begin
        div_n = prod_q;
        div_d = DivW'(decel_q);
      end
      OP_RAMP_GO: begin
        div_n = DivW'(dvd_mag);
        div_d = DivW'(dsr_mag);
      end
      default: div_go = 1'b0;
    endcase
  end

  str_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (div_go),
    .n_i    (div_n),
    .d_i    (div_d),
    .done_o (div_done),
    .q_o    (div_q),
    .r_o    (div_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_STOP;
      dir_q        <= 1'b0;
      half_q       <= 1'b0;
      moving_q     <= 1'b0;
      done_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      cur_q        <= '0;
      min_q        <= '0;
      last_q       <= '0;
      rc_q         <= '0;
      dv_q         <= '0;
      rem_q        <= '0;
      dss_q        <= '0;
      steps_done_q <= '0;
      pos_q        <= '0;
    end else begin
      if (out_valid_q && out_ready_i && cmd_i.op != OP_OUT) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_LOAD: begin
          if (!in_data_i.mode) begin
            dir_q    <= in_data_i.steps[31];
            moving_q <= 1'b1;
            done_q   <= 1'b0;
          end else begin
            half_q <= ~half_q;
          end
        end
        OP_ONE: begin
          rc_q    <= -33'sd1;
          phase_q <= PH_DECEL;
          cur_q   <= DelayWidth'(cfg_i.single_delay);
        end
        OP_MD: begin
          if (speed_q == '0 || div_q > DelayMax) min_q <= DelayWidth'(DelayMax);
          else min_q <= DelayWidth'(div_q);
        end
        OP_DV_AL: dv_q <= (dv_al == '0) ? -33'sd1 : dv_al;
        OP_DV_Q: begin
          // A quotient of exactly 2^32 negates to the 33-bit minimum by wrapping.
          if (decel_q == '0 || div_q > Two32) dv_q <= {1'b1, 32'd0};
          else if (div_q == '0) dv_q <= -33'sd1;
          else dv_q <= -$signed(div_q[32:0]);
        end
        OP_START_FIN: begin
          if (ds_s[33]) dss_q <= '0;
          else if (ds_s[32]) dss_q <= '1;
          else dss_q <= ds_s[31:0];
          rc_q <= '0;
          if (c0_d <= min_q) begin
            cur_q   <= min_q;
            phase_q <= PH_RUN;
          end else begin
            cur_q   <= c0_d;
            phase_q <= PH_ACCEL;
          end
        end
        OP_STOP_STEP: begin
          steps_done_q <= '0;
          rem_q        <= '0;
          moving_q     <= 1'b0;
          cur_q        <= '0;
        end
        OP_RUN_STEP: begin
          steps_done_q <= step_next;
          pos_q        <= dir_q ? pos_q - 1'b1 : pos_q + 1'b1;
          if (step_next >= dss_q) begin
            rc_q    <= dv_q;
            cur_q   <= last_q;
            phase_q <= PH_DECEL;
          end else begin
            cur_q <= min_q;
          end
        end
        OP_RAMP_PREP: begin
          steps_done_q <= step_next;
          pos_q        <= dir_q ? pos_q - 1'b1 : pos_q + 1'b1;
          rc_q         <= rc_q + 33'sd1;
        end
        OP_RAMP_Q: rem_q <= clamp33(r_s);
        OP_RAMP_UPD: begin
          if (phase_q == PH_ACCEL) begin
            if (steps_done_q >= dss_q) begin
              rc_q    <= dv_q;
              cur_q   <= nd_q;
              phase_q <= PH_DECEL;
            end else if (nd_q <= min_q) begin
              last_q  <= nd_q;
              cur_q   <= min_q;
              rem_q   <= '0;
              phase_q <= PH_RUN;
            end else begin
              cur_q <= nd_q;
            end
          end else begin
            cur_q <= nd_q;
            if (!rc_q[32]) begin
              phase_q <= PH_STOP;
              done_q  <= 1'b1;
            end
          end
        end
        OP_OUT: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        mode_q  <= in_data_i.mode;
        mag_q   <= in_data_i.steps[31] ? 32'(-in_data_i.steps) : 32'(in_data_i.steps);
        accel_q <= in_data_i.accel;
        decel_q <= in_data_i.decel;
        speed_q <= in_data_i.speed;
        c0_q    <= in_data_i.first_delay;
        shown_q <= cur_w[15:0];
      end
      OP_MD:  prod_q <= DivW'(32'(speed_q) * 32'(speed_q));
      OP_NUM: num_q  <= DivW'(prod_q[31:0]) * DivW'(SpeedSqScale);
      OP_DEN: prod_q <= DivW'(cfg_i.speed_scale) * DivW'(accel_q);
      OP_MSL: begin
        msl_q  <= (prod_q == '0) ? 32'hFFFF_FFFF : sat32nz(div_q);
        prod_q <= DivW'(mag_q) * DivW'(decel_q);
      end
      OP_AL: begin
        al_q <= (accel_q == '0 && decel_q == '0) ? 32'hFFFF_FFFF : sat32nz(div_q);
      end
      OP_DV_AL, OP_DV_GO: ;
      OP_RAMP_GO: begin
        nneg_q <= dvd_s[39];
        qneg_q <= dvd_s[39] ^ dsr_s[39];
      end
      OP_RAMP_Q: begin
        if (nd_s[39]) nd_q <= '0;
        else if (nd_s > DelayMaxS) nd_q <= DelayWidth'(DelayMax);
        else nd_q <= nd_s[DelayWidth-1:0];
      end
      OP_OUT: begin
        out_q.pulse_level <= half_q;
        out_q.next_delay  <= mode_q ? shown_q : cur_w[15:0];
        out_q.position    <= 32'(pos_q);
        out_q.moving      <= moving_q;
        out_q.move_done   <= done_q;
        out_q.phase       <= phase_q;
        out_q.direction   <= dir_q;
      end
      default: ;
    endcase
    // The product for the deceleration count is only needed on the long branch.
    if (cmd_i.op == OP_AL) begin
      prod_q <= DivW'(msl_q) * DivW'(accel_q);
    end
  end

  assign status_o.div_done  = div_done;
  assign status_o.mode      = mode_q;
  assign status_o.full      = ~half_q;
  assign status_o.mag_zero  = (mag_q == '0);
  assign status_o.mag_one   = (mag_q == 32'd1);
  assign status_o.al_le_msl = (al_q <= msl_q);
  assign status_o.out_busy  = out_valid_q && !out_ready_i;
  assign status_o.phase     = phase_q;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/str_ctrl.sv =====
`timescale 1ns / 1ps
module str_ctrl import str_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_ONE,
    ST_MD_GO,
    ST_MD_WAIT,
    ST_MD,
    ST_NUM,
    ST_DEN,
    ST_MSL_GO,
    ST_MSL_WAIT,
    ST_MSL,
    ST_AL_GO,
    ST_AL_WAIT,
    ST_AL,
    ST_BRANCH,
    ST_DV_WAIT,
    ST_DV_Q,
    ST_START_FIN,
    ST_STOP_STEP,
    ST_RUN_STEP,
    ST_RAMP_PREP,
    ST_RAMP_GO,
    ST_RAMP_WAIT,
    ST_RAMP_Q,
    ST_RAMP_UPD,
    ST_OUT
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!status_i.mode) begin
          if (status_i.mag_zero) state_d = ST_OUT;
          else if (status_i.mag_one) state_d = ST_ONE;
          else state_d = ST_MD_GO;
        end else if (!status_i.full) begin
          state_d = ST_OUT;
        end else begin
          case (status_i.phase)
            PH_STOP: state_d = ST_STOP_STEP;
            PH_RUN:  state_d = ST_RUN_STEP;
            default: state_d = ST_RAMP_PREP;
          endcase
        end
      end
      ST_ONE: begin
        cmd_o.op = OP_ONE;
        state_d  = ST_OUT;
      end
      ST_MD_GO: begin
        cmd_o.op = OP_MD_GO;
        state_d  = ST_MD_WAIT;
      end
      ST_MD_WAIT: if (status_i.div_done) state_d = ST_MD;
      ST_MD: begin
        cmd_o.op = OP_MD;
        state_d  = ST_NUM;
      end
      ST_NUM: begin
        cmd_o.op = OP_NUM;
        state_d  = ST_DEN;
      end
      ST_DEN: begin
        cmd_o.op = OP_DEN;
        state_d  = ST_MSL_GO;
      end
      ST_MSL_GO: begin
        cmd_o.op = OP_MSL_GO;
        state_d  = ST_MSL_WAIT;
      end
      ST_MSL_WAIT: if (status_i.div_done) state_d = ST_MSL;
      ST_MSL: begin
        cmd_o.op = OP_MSL;
        state_d  = ST_AL_GO;
      end
      ST_AL_GO: begin
        cmd_o.op = OP_AL_GO;
        state_d  = ST_AL_WAIT;
      end
      ST_AL_WAIT: if (status_i.div_done) state_d = ST_AL;
      ST_AL: begin
        cmd_o.op = OP_AL;
        state_d  = ST_BRANCH;
      end
      ST_BRANCH: begin
        // Short moves decelerate from the acceleration limit without a further division.
        if (status_i.al_le_msl) begin
          cmd_o.op = OP_DV_AL;
          state_d  = ST_START_FIN;
        end else begin
          cmd_o.op = OP_DV_GO;
          state_d  = ST_DV_WAIT;
        end
      end
      ST_DV_WAIT: if (status_i.div_done) state_d = ST_DV_Q;
      ST_DV_Q: begin
        cmd_o.op = OP_DV_Q;
        state_d  = ST_START_FIN;
      end
      ST_START_FIN: begin
        cmd_o.op = OP_START_FIN;
        state_d  = ST_OUT;
      end
      ST_STOP_STEP: begin
        cmd_o.op = OP_STOP_STEP;
        state_d  = ST_OUT;
      end
      ST_RUN_STEP: begin
        cmd_o.op = OP_RUN_STEP;
        state_d  = ST_OUT;
      end
      ST_RAMP_PREP: begin
        cmd_o.op = OP_RAMP_PREP;
        state_d  = ST_RAMP_GO;
      end
      ST_RAMP_GO: begin
        cmd_o.op = OP_RAMP_GO;
        state_d  = ST_RAMP_WAIT;
      end
      ST_RAMP_WAIT: if (status_i.div_done) state_d = ST_RAMP_Q;
      ST_RAMP_Q: begin
        cmd_o.op = OP_RAMP_Q;
        state_d  = ST_RAMP_UPD;
      end
      ST_RAMP_UPD: begin
        cmd_o.op = OP_RAMP_UPD;
        state_d  = ST_OUT;
      end
      ST_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.op = OP_OUT;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/stepper_trapezoid_ramp.sv =====
// Transactions: a compare event that completes no step goes straight to the result, one in the
// stop or run phase first takes a step update, and one in accel or decel also runs a division.
// A start of two or more steps runs four divisions on the shared divider, the last only when
// the deceleration count needs one; a start of zero or one step needs no division.
// One transaction is processed at a time: a new input is taken only once the last result is issued.
// Reset (rst_ni low, asynchronous) clears all motion state and loads the register defaults.
`timescale 1ns / 1ps
module stepper_trapezoid_ramp import str_pkg::*; #(
  parameter int unsigned DelayWidth = DelayWidthDef,
  parameter int unsigned PosWidth   = PosWidthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t    cfg_q;
  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rate_constant <= RateConstRst;
      cfg_q.speed_scale   <= SpeedScaleRst;
      cfg_q.single_delay  <= SingleDelayRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgRate:   cfg_q.rate_constant <= cfg_data_i;
        CfgScale:  cfg_q.speed_scale   <= cfg_data_i[19:0];
        CfgSingle: cfg_q.single_delay  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  str_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  str_dp #(
    .DelayWidth (DelayWidth),
    .PosWidth   (PosWidth)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/str_chk.sv =====
`timescale 1ns / 1ps
module str_chk import str_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input in_t         in_data_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input out_t        out_data_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [1:0]  cfg_index_i,
  input logic [31:0] cfg_data_i
);

  // A result waiting for the sink is held unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // Only one transaction is in flight.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while busy");

  a_done_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.move_done |-> out_data_o.phase == PH_STOP)
    else $error("move done outside stop phase");

  a_idle_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.moving |-> out_data_o.phase == PH_STOP)
    else $error("not moving outside stop phase");

endmodule

bind stepper_trapezoid_ramp str_chk u_str_chk (.*);
